/* rtl/b64d_pkg.sv */
// Shared types and constants for the base64 stream decoder.
package b64d_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned SEXTET_W    = 6;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GROUP_BYTES = 3;
    localparam int unsigned COUNT_W     = 2;

    // One decoded group, bytes packed from index 0 up; count is 1..3.
    typedef struct packed {
        logic [GROUP_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [COUNT_W-1:0]                 count;
    } group_t;

endpackage

/* rtl/b64d_in_if.sv */
// Input channel: one encoded character per beat, with end-of-text flag.
interface b64d_in_if
    import b64d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

/* rtl/b64d_out_if.sv */
// Output channel: one decoded byte per beat, with last-of-item flag.
interface b64d_out_if
    import b64d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

/* rtl/b64d_group.sv */
// Character decode, group assembly and group byte formation.
module b64d_group
    import b64d_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    b64d_in_if.sink        in_ch,
    input  logic           buf_free,
    output logic           grp_load,
    output group_t         grp
);

    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_DIG_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3d;

    localparam logic [SEXTET_W-1:0] SX_LO_BASE  = 6'd26;
    localparam logic [SEXTET_W-1:0] SX_DIG_BASE = 6'd52;
    localparam logic [SEXTET_W-1:0] SX_PLUS     = 6'd62;
    localparam logic [SEXTET_W-1:0] SX_SLASH    = 6'd63;

    localparam logic [COUNT_W-1:0] CNT_FULL  = 2'd3;
    localparam logic [COUNT_W-1:0] CNT_THIRD = 2'd2;

    logic [2:0][SEXTET_W-1:0] held_reg, held_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     tpad_reg, tpad_next;

    logic                     kept;
    logic                     is_pad;
    logic [SEXTET_W-1:0]      sextet;
    logic [CHAR_W-1:0]        diff;
    logic                     complete;
    logic                     flush;
    logic                     emit;
    logic                     accept;
    logic [2:0][SEXTET_W-1:0] upd_held;
    logic [COUNT_W-1:0]       upd_count;
    logic                     upd_tpad;
    logic [SEXTET_W-1:0]      s1, s2, s3, s4;
    logic                     third_pad, fourth_pad;
    logic [BYTE_W-1:0]        b1, b2, b3;

    // Character to sextet map
    always_comb
    begin
        kept   = 1'b1;
        is_pad = (in_ch.in_char == CH_PAD);
        sextet = SX_SLASH;
        diff   = '0;
        if (in_ch.in_char >= CH_UP_A && in_ch.in_char <= CH_UP_Z)
        begin
            diff   = in_ch.in_char - CH_UP_A;
            sextet = diff[SEXTET_W-1:0];
        end
        else if (in_ch.in_char >= CH_LO_A && in_ch.in_char <= CH_LO_Z)
        begin
            diff   = in_ch.in_char - CH_LO_A;
            sextet = diff[SEXTET_W-1:0] + SX_LO_BASE;
        end
        else if (in_ch.in_char >= CH_DIG_0 && in_ch.in_char <= CH_DIG_9)
        begin
            diff   = in_ch.in_char - CH_DIG_0;
            sextet = diff[SEXTET_W-1:0] + SX_DIG_BASE;
        end
        else if (in_ch.in_char == CH_PLUS)
        begin
            sextet = SX_PLUS;
        end
        else if (in_ch.in_char == CH_SLASH || is_pad)
        begin
            sextet = SX_SLASH;
        end
        else
        begin
            kept = 1'b0;
        end
    end

    // Group update and emit decision
    always_comb
    begin
        complete  = kept && (count_reg == CNT_FULL);
        upd_held  = held_reg;
        upd_count = count_reg;
        upd_tpad  = tpad_reg;
        if (kept && !complete)
        begin
            upd_held[count_reg] = sextet;
            if (count_reg == CNT_THIRD)
            begin
                upd_tpad = is_pad;
            end
            upd_count = count_reg + 2'd1;
        end
        flush = !complete && in_ch.end_of_text && (upd_count != '0);
        emit  = complete || flush;

        if (complete)
        begin
            s1 = held_reg[0];
            s2 = held_reg[1];
            s3 = held_reg[2];
            s4 = sextet;
            third_pad  = tpad_reg;
            fourth_pad = is_pad;
        end
        else
        begin
            // short group: missing slots are already zero ('A')
            s1 = upd_held[0];
            s2 = upd_held[1];
            s3 = upd_held[2];
            s4 = '0;
            third_pad  = upd_tpad;
            fourth_pad = 1'b0;
        end

        b1 = {s1, s2[5:4]};
        b2 = {s2[3:0], s3[5:2]};
        b3 = {s3[1:0], s4};

        grp.bytes[0] = b1;
        grp.bytes[1] = third_pad ? b3 : b2;
        grp.bytes[2] = b3;
        grp.count    = 2'd1 + {1'b0, !third_pad} + {1'b0, !fourth_pad};

        if (emit)
        begin
            held_next  = '0;
            count_next = '0;
            tpad_next  = 1'b0;
        end
        else
        begin
            held_next  = upd_held;
            count_next = upd_count;
            tpad_next  = upd_tpad;
        end
    end

    // Items that emit nothing never wait on the output side
    assign in_ch.ready = buf_free || !emit;
    assign accept      = in_ch.valid && in_ch.ready;
    assign grp_load    = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            count_reg <= '0;
            tpad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            held_reg  <= held_next;
            count_reg <= count_next;
            tpad_reg  <= tpad_next;
        end
    end

endmodule

/* rtl/b64d_serializer.sv */
// Result register: holds one decoded group and sends it one byte per beat.
module b64d_serializer
    import b64d_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           grp_load,
    input  group_t         grp,
    output logic           buf_free,
    b64d_out_if.source     out_ch
);

    logic [GROUP_BYTES-1:0][BYTE_W-1:0] bytes_reg;
    logic [COUNT_W-1:0]                 count_reg;
    logic [COUNT_W-1:0]                 idx_reg, idx_next;
    logic                               valid_reg;
    logic                               last_byte;

    assign last_byte = (idx_reg == count_reg - 2'd1);
    assign buf_free  = !valid_reg || (out_ch.ready && last_byte);
    assign idx_next  = idx_reg + 2'd1;

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_ch.out_byte = bytes_reg[0];
            2'd1:    out_ch.out_byte = bytes_reg[1];
            default: out_ch.out_byte = bytes_reg[2];
        endcase
    end

    assign out_ch.valid    = valid_reg;
    assign out_ch.run_last = last_byte;

    always_ff @(posedge clk)
    begin
        if (grp_load)
        begin
            bytes_reg <= grp.bytes;
            count_reg <= grp.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (grp_load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && out_ch.ready)
        begin
            if (last_byte)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_next;
            end
        end
    end

endmodule

/* rtl/base64_stream_decoder.sv */
// Base64 stream decoder: one character per input beat, decoded bytes out.
// Characters outside A-Z, a-z, 0-9, '+', '/', '=' are dropped. Kept
// characters collect in groups of four; a full group, or a partial group
// closed by end_of_text (missing places taken as 'A'), yields one to three
// bytes: byte two is dropped when the third character is '=', byte three
// when the fourth is '='. run_last marks the final byte of the bytes caused
// by one input beat. An input beat is taken every cycle unless it would
// emit a group while the result register still holds bytes of the
// previous group; bytes leave at one per cycle unless the output stalls,
// so a full group of three bytes every four characters streams at one
// character per cycle. The first byte is valid in the cycle after its
// group is accepted. Control state resets asynchronously on rst_n low;
// the byte buffer of the result register has no reset and is always
// loaded before it is shown. No clearing pass is needed.
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    b64d_in_if.sink     in_ch,
    b64d_out_if.source  out_ch
);

    // group assembly -> result register handoff
    logic   grp_load;
    logic   buf_free;
    group_t grp;

    // Decodes characters and forms groups of bytes.
    b64d_group u_group (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .buf_free (buf_free),
        .grp_load (grp_load),
        .grp      (grp)
    );

    // Holds one group and sends its bytes, one per beat.
    b64d_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .grp_load (grp_load),
        .grp      (grp),
        .buf_free (buf_free),
        .out_ch   (out_ch)
    );

endmodule

/* rtl/b64d_checker.sv */
// Port-level checks for the base64 stream decoder, bound to the top level.
module b64d_port_checker
    import b64d_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              run_last
);

    // stalled output beat stays
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_byte) && $stable(run_last)))
        else $error("output payload changed while stalled");

    // bytes only appear as a result of an accepted input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("output started without an accepted input beat");

    // a group is never cut short
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !run_last) |=> out_valid)
        else $error("group ended without run_last");

endmodule

bind base64_stream_decoder b64d_port_checker u_b64d_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .run_last  (out_ch.run_last)
);
